/* sv/rdvd_pkg.sv */
// ----------------------------------------------------------------------------
// rdvd_pkg: shared types and constants of the range dip vehicle detector
// Phase, controller state and register index codes, reset values of the
// configuration registers and the packed widths of the stream payloads.
// ----------------------------------------------------------------------------
package rdvd_pkg;

  // Default sizes
  localparam int unsigned HIST_BINS_DEF     = 8192;
  localparam int unsigned EVENT_SAMPLES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // Payload widths
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 120;
  localparam int unsigned VAR_W       = 34;
  localparam int unsigned GRAD_W      = 20;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Fixed values
  localparam logic [15:0] HIST_MAX     = 16'hFFFF;
  localparam logic [15:0] BASELINE_RST = 16'd225;

  // Register reset values
  localparam logic [23:0] CAL_MS_RST   = 24'd60000;
  localparam logic [15:0] MERGE_MS_RST = 16'd200;
  localparam logic [15:0] MIN_EV_RST   = 16'd500;
  localparam logic [15:0] MAX_EV_RST   = 16'd10000;
  localparam logic [11:0] DIP_MRG_RST  = 12'd10;
  localparam logic [11:0] MIN_HGT_RST  = 12'd30;
  localparam logic [31:0] VAR_LIM_RST  = 32'd4800;
  localparam logic [15:0] GRAD_LIM_RST = 16'd35;

  typedef enum logic {
    OP_SAMPLE,
    OP_TRIGGER
  } op_e;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_CAL,
    PH_IDLE,
    PH_DIP,
    PH_MERGE
  } phase_e;

  typedef enum logic [1:0] {
    FS_CLEAR,
    FS_READY,
    FS_EXEC
  } fstate_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL1,
    BS_MUL2,
    BS_DIV1,
    BS_DIV2,
    BS_OUT
  } bstate_e;

  typedef enum logic [2:0] {
    CFG_CAL_MS,
    CFG_MERGE_MS,
    CFG_MIN_EV,
    CFG_MAX_EV,
    CFG_DIP_MRG,
    CFG_MIN_HGT,
    CFG_VAR_LIM,
    CFG_GRAD_LIM
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] calibration_ms;
    logic [15:0] merge_gap_ms;
    logic [15:0] min_event_ms;
    logic [15:0] max_event_ms;
    logic [11:0] dip_margin;
    logic [11:0] min_height;
    logic [31:0] variance_limit;
    logic [15:0] gradient_limit;
  } cfg_t;

endpackage

/* sv/rdvd_queue.sv */
// ----------------------------------------------------------------------------
// rdvd_queue: short register queue between front and back end
// Holds closed events that passed the tests until the back end takes them.
// ----------------------------------------------------------------------------
module rdvd_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = rdvd_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign in_ready_o  = count_q < CW'(DEPTH);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill level above depth");
  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill level did not follow a push");
`endif

endmodule

/* sv/rdvd_front.sv */
// ----------------------------------------------------------------------------
// rdvd_front: sample classification, calibration histogram and dip tracking
// Reads the histogram bin in the accept cycle and updates all state in the
// execute state, held on a queue stall; passing closed events go to the queue.
// ----------------------------------------------------------------------------
module rdvd_front #(
  parameter int unsigned HIST_BINS     = rdvd_pkg::HIST_BINS_DEF,
  parameter int unsigned EVENT_SAMPLES = rdvd_pkg::EVENT_SAMPLES_DEF,
  parameter int unsigned REC_W         = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdvd_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_op_i,
  input  logic [31:0]         in_time_i,
  input  logic [15:0]         in_dist_i,
  output logic                rec_valid_o,
  input  logic                rec_ready_i,
  output logic [REC_W-1:0]    rec_o
);

  localparam int unsigned HB_W = $clog2(HIST_BINS);
  localparam int unsigned CW   = $clog2(EVENT_SAMPLES + 1);
  localparam int unsigned SW   = 16 + CW;
  localparam int unsigned QW   = 32 + CW;

  rdvd_pkg::fstate_e state_q, state_d;
  rdvd_pkg::phase_e  phase_q, phase_d;

  logic [HB_W-1:0] clr_addr_q;
  logic            op_q;
  logic [31:0]     t_q;
  logic [15:0]     d_q;
  logic [31:0]     dsq_q;
  logic [15:0]     rd_q;

  logic [31:0]     cal_start_q;
  logic [HB_W-1:0] best_bin_q;
  logic [15:0]     best_cnt_q;
  logic [15:0]     baseline_q;
  logic [31:0]     prev_t_q;
  logic [15:0]     prev_d_q;
  logic [31:0]     prev_sq_q;
  logic            prev_valid_q;
  logic [31:0]     last_dip_q;

  logic [CW-1:0]   cnt_q;
  logic [31:0]     first_q, last_t_q;
  logic [15:0]     last_d_q, min_q;
  logic [SW-1:0]   sum_q, step_q;
  logic [QW-1:0]   sq_q;

  logic [15:0]     hist_mem [HIST_BINS];
  logic            hist_we, hist_re;
  logic [HB_W-1:0] hist_wa;
  logic [15:0]     hist_wd;

  // Classification of the held item
  logic            sample, in_win, in_range, hit, best_upd, below, gap_long;
  logic            dip_start, do_store, close_ev, pass, push, stall, commit;
  logic [31:0]     age, gap, dur;
  logic [15:0]     cnt_inc;
  logic [17:0]     thr_dip, thr_hgt;

  logic [CW-1:0]   a_cnt, b_cnt;
  logic [31:0]     a_first, b_first, a_lt, b_lt;
  logic [15:0]     a_min, b_min, a_ld, b_ld, adiff;
  logic [SW-1:0]   a_sum, b_sum, a_step, b_step;
  logic [QW-1:0]   a_sq, b_sq;

  assign sample   = op_q == rdvd_pkg::OP_SAMPLE;
  assign age      = t_q - cal_start_q;
  assign in_win   = age < {8'd0, cfg_i.calibration_ms};
  assign in_range = {1'b0, d_q} < 17'(HIST_BINS);
  assign hit      = in_range && (rd_q != rdvd_pkg::HIST_MAX);
  assign cnt_inc  = rd_q + 16'd1;
  assign best_upd = (cnt_inc > best_cnt_q) ||
                    ((cnt_inc == best_cnt_q) && (d_q[HB_W-1:0] < best_bin_q));
  assign thr_dip  = {2'b00, baseline_q} - {6'd0, cfg_i.dip_margin};
  assign thr_hgt  = {2'b00, baseline_q} - {6'd0, cfg_i.min_height};
  assign below    = $signed({2'b00, d_q}) < $signed(thr_dip);
  assign gap      = t_q - last_dip_q;
  assign gap_long = gap > {16'd0, cfg_i.merge_gap_ms};

  assign dip_start = sample && (phase_q == rdvd_pkg::PH_IDLE) && below;
  assign do_store  = sample && (dip_start || (phase_q == rdvd_pkg::PH_DIP) ||
                                (phase_q == rdvd_pkg::PH_MERGE));
  assign close_ev  = sample && (phase_q == rdvd_pkg::PH_MERGE) && !below && gap_long;

  // Build event accumulators: restart with context point, then store sample
  always_comb begin
    a_cnt   = cnt_q;
    a_first = first_q;
    a_min   = min_q;
    a_sum   = sum_q;
    a_sq    = sq_q;
    a_step  = step_q;
    a_lt    = last_t_q;
    a_ld    = last_d_q;
    if (dip_start) begin
      a_cnt   = prev_valid_q ? CW'(1) : '0;
      a_first = prev_t_q;
      a_min   = prev_d_q;
      a_sum   = prev_valid_q ? SW'(prev_d_q) : '0;
      a_sq    = prev_valid_q ? QW'(prev_sq_q) : '0;
      a_step  = '0;
      a_lt    = prev_t_q;
      a_ld    = prev_d_q;
    end
    adiff   = (d_q > a_ld) ? (d_q - a_ld) : (a_ld - d_q);
    b_cnt   = a_cnt;
    b_first = a_first;
    b_min   = a_min;
    b_sum   = a_sum;
    b_sq    = a_sq;
    b_step  = a_step;
    b_lt    = a_lt;
    b_ld    = a_ld;
    if (do_store && (a_cnt < CW'(EVENT_SAMPLES))) begin
      if (a_cnt == '0) begin
        b_first = t_q;
        b_min   = d_q;
      end else begin
        b_step = a_step + SW'(adiff);
        b_min  = (d_q < a_min) ? d_q : a_min;
      end
      b_sum = a_sum + SW'(d_q);
      b_sq  = a_sq + QW'(dsq_q);
      b_lt  = t_q;
      b_ld  = d_q;
      b_cnt = a_cnt + 1'b1;
    end
  end

  // Duration and depth tests of a closing event
  assign dur    = b_lt - b_first;
  assign pass   = (dur >= {16'd0, cfg_i.min_event_ms}) &&
                  (dur <= {16'd0, cfg_i.max_event_ms}) &&
                  ($signed({2'b00, b_min}) < $signed(thr_hgt));
  assign push   = (state_q == rdvd_pkg::FS_EXEC) && close_ev && pass;
  assign stall  = push && !rec_ready_i;
  assign commit = (state_q == rdvd_pkg::FS_EXEC) && !stall;
  assign rec_o  = {b_step, b_sq, b_sum, b_cnt, b_min, dur[15:0], b_first};

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (!sample) begin
      if (phase_q == rdvd_pkg::PH_WAIT) begin
        phase_d = rdvd_pkg::PH_CAL;
      end
    end else begin
      case (phase_q)
        rdvd_pkg::PH_CAL: begin
          if (!in_win) phase_d = rdvd_pkg::PH_IDLE;
        end
        rdvd_pkg::PH_IDLE: begin
          if (below) phase_d = rdvd_pkg::PH_DIP;
        end
        rdvd_pkg::PH_DIP: begin
          if (!below) phase_d = rdvd_pkg::PH_MERGE;
        end
        rdvd_pkg::PH_MERGE: begin
          if (below) begin
            phase_d = rdvd_pkg::PH_DIP;
          end else if (gap_long) begin
            phase_d = rdvd_pkg::PH_IDLE;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Next controller state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rdvd_pkg::FS_CLEAR: begin
        if (clr_addr_q == HB_W'(HIST_BINS - 1)) state_d = rdvd_pkg::FS_READY;
      end
      rdvd_pkg::FS_READY: begin
        if (in_valid_i) state_d = rdvd_pkg::FS_EXEC;
      end
      rdvd_pkg::FS_EXEC: begin
        if (!stall) state_d = rdvd_pkg::FS_READY;
      end
      default: state_d = rdvd_pkg::FS_CLEAR;
    endcase
  end

  // Controller outputs and histogram port
  always_comb begin
    in_ready_o  = state_q == rdvd_pkg::FS_READY;
    rec_valid_o = push;
    hist_re     = in_valid_i && (state_q == rdvd_pkg::FS_READY);
    hist_we     = 1'b0;
    hist_wa     = d_q[HB_W-1:0];
    hist_wd     = cnt_inc;
    case (state_q)
      rdvd_pkg::FS_CLEAR: begin
        hist_we = 1'b1;
        hist_wa = clr_addr_q;
        hist_wd = '0;
      end
      rdvd_pkg::FS_EXEC: begin
        hist_we = commit && sample && (phase_q == rdvd_pkg::PH_CAL) && in_win && hit;
      end
      default: hist_we = 1'b0;
    endcase
  end

  // Histogram memory
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (hist_re) begin
      rd_q <= hist_mem[in_dist_i[HB_W-1:0]];
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (hist_re) begin
      op_q  <= in_op_i;
      t_q   <= in_time_i;
      d_q   <= in_dist_i;
      dsq_q <= in_dist_i * in_dist_i;
    end
  end

  // Control and detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rdvd_pkg::FS_CLEAR;
      phase_q      <= rdvd_pkg::PH_WAIT;
      clr_addr_q   <= '0;
      cal_start_q  <= '0;
      best_bin_q   <= '0;
      best_cnt_q   <= '0;
      baseline_q   <= rdvd_pkg::BASELINE_RST;
      prev_t_q     <= '0;
      prev_d_q     <= '0;
      prev_sq_q    <= '0;
      prev_valid_q <= 1'b0;
      last_dip_q   <= '0;
      cnt_q        <= '0;
      first_q      <= '0;
      last_t_q     <= '0;
      last_d_q     <= '0;
      min_q        <= '0;
      sum_q        <= '0;
      sq_q         <= '0;
      step_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rdvd_pkg::FS_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (commit) begin
        phase_q <= phase_d;
        if (!sample) begin
          if (phase_q == rdvd_pkg::PH_WAIT) begin
            cal_start_q <= t_q;
            best_bin_q  <= '0;
            best_cnt_q  <= '0;
          end
        end else begin
          prev_t_q     <= t_q;
          prev_d_q     <= d_q;
          prev_sq_q    <= dsq_q;
          prev_valid_q <= 1'b1;
          if (phase_q == rdvd_pkg::PH_CAL) begin
            if (!in_win) begin
              baseline_q <= 16'(best_bin_q);
            end else if (hit && best_upd) begin
              best_cnt_q <= cnt_inc;
              best_bin_q <= d_q[HB_W-1:0];
            end
          end
          if (do_store && below) begin
            last_dip_q <= t_q;
          end
          cnt_q    <= close_ev ? '0 : b_cnt;
          sum_q    <= close_ev ? '0 : b_sum;
          sq_q     <= close_ev ? '0 : b_sq;
          step_q   <= close_ev ? '0 : b_step;
          first_q  <= b_first;
          last_t_q <= b_lt;
          last_d_q <= b_ld;
          min_q    <= b_min;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rdvd_pkg::PH_WAIT && !(commit && !sample)) |=>
    (phase_q == rdvd_pkg::PH_WAIT))
    else $error("left waiting phase without a trigger");
  a_push_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> (phase_q == rdvd_pkg::PH_MERGE))
    else $error("event pushed outside merge phase");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(EVENT_SAMPLES))
    else $error("stored point count above buffer size");
  a_hist_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> (state_q == rdvd_pkg::FS_CLEAR || phase_q == rdvd_pkg::PH_CAL))
    else $error("histogram written outside clearing or calibration");
`endif

endmodule

/* sv/rdvd_back.sv */
// ----------------------------------------------------------------------------
// rdvd_back: event statistics
// Forms n*sum(d^2) - sum(d)^2 with a shift-add multiplier, then divides it
// and the step sum with one restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdvd_back #(
  parameter int unsigned EVENT_SAMPLES = rdvd_pkg::EVENT_SAMPLES_DEF,
  parameter int unsigned REC_W         = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rdvd_pkg::cfg_t                      cfg_i,
  input  logic                                rec_valid_i,
  output logic                                rec_ready_o,
  input  logic [REC_W-1:0]                    rec_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rdvd_pkg::OUT_TDATA_W-1:0]    out_data_o,
  output logic                                out_vehicle_o
);

  localparam int unsigned CW  = $clog2(EVENT_SAMPLES + 1);
  localparam int unsigned SW  = 16 + CW;
  localparam int unsigned QW  = 32 + CW;
  localparam int unsigned PW  = CW + QW;
  localparam int unsigned DW  = PW + 4;
  localparam int unsigned NW  = 2 * CW;
  localparam int unsigned DCW = $clog2(DW + 1);

  rdvd_pkg::bstate_e state_q, state_d;

  // Unpacked record fields
  logic [31:0]   r_first;
  logic [15:0]   r_dur, r_min;
  logic [CW-1:0] r_cnt;
  logic [SW-1:0] r_sum, r_step;
  logic [QW-1:0] r_sq;

  logic [31:0]   first_q;
  logic [15:0]   dur_q, min_q;
  logic [CW-1:0] n_q;
  logic [SW-1:0] sum_q, step_q;
  logic [SW-1:0] mul_a_q;
  logic [PW-1:0] mul_b_q, acc_q, p1_q;
  logic [DW-1:0] div_q, var_q;
  logic [NW-1:0] rem_q, den_q;
  logic [DCW-1:0] dcnt_q;
  logic [rdvd_pkg::OUT_TDATA_W-1:0] out_q;
  logic          veh_q;

  logic          mul_done, div_done, few;
  logic [PW-1:0] dnum;
  logic [NW:0]   r_sh, r_new;
  logic          ge;

  assign {r_step, r_sq, r_sum, r_cnt, r_min, r_dur, r_first} = rec_i;

  assign mul_done = mul_a_q == '0;
  assign div_done = dcnt_q == DCW'(DW);
  assign few      = n_q < CW'(2);
  assign dnum     = p1_q - acc_q;

  // One restoring divide step
  assign r_sh  = {rem_q, div_q[DW-1]};
  assign ge    = r_sh >= {1'b0, den_q};
  assign r_new = ge ? (r_sh - {1'b0, den_q}) : r_sh;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rdvd_pkg::BS_IDLE: if (rec_valid_i) state_d = rdvd_pkg::BS_MUL1;
      rdvd_pkg::BS_MUL1: if (mul_done) state_d = rdvd_pkg::BS_MUL2;
      rdvd_pkg::BS_MUL2: begin
        if (mul_done) state_d = few ? rdvd_pkg::BS_OUT : rdvd_pkg::BS_DIV1;
      end
      rdvd_pkg::BS_DIV1: if (div_done) state_d = rdvd_pkg::BS_DIV2;
      rdvd_pkg::BS_DIV2: if (div_done) state_d = rdvd_pkg::BS_OUT;
      rdvd_pkg::BS_OUT:  if (out_ready_i) state_d = rdvd_pkg::BS_IDLE;
      default: state_d = rdvd_pkg::BS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rec_ready_o   = state_q == rdvd_pkg::BS_IDLE;
    out_valid_o   = state_q == rdvd_pkg::BS_OUT;
    out_data_o    = out_q;
    out_vehicle_o = veh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdvd_pkg::BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: multiply, divide and format the result
  always_ff @(posedge clk_i) begin
    case (state_q)
      rdvd_pkg::BS_IDLE: begin
        if (rec_valid_i) begin
          first_q <= r_first;
          dur_q   <= r_dur;
          min_q   <= r_min;
          n_q     <= r_cnt;
          sum_q   <= r_sum;
          step_q  <= r_step;
          mul_a_q <= SW'(r_cnt);
          mul_b_q <= PW'(r_sq);
          acc_q   <= '0;
        end
      end
      rdvd_pkg::BS_MUL1: begin
        if (mul_done) begin
          p1_q    <= acc_q;
          mul_a_q <= sum_q;
          mul_b_q <= PW'(sum_q);
          acc_q   <= '0;
        end else begin
          if (mul_a_q[0]) acc_q <= acc_q + mul_b_q;
          mul_a_q <= mul_a_q >> 1;
          mul_b_q <= mul_b_q << 1;
        end
      end
      rdvd_pkg::BS_MUL2: begin
        if (mul_done) begin
          if (few) begin
            out_q <= {2'b00, rdvd_pkg::GRAD_W'(0), rdvd_pkg::VAR_W'(0),
                      min_q, dur_q, first_q};
            veh_q <= (cfg_i.variance_limit != '0) && (cfg_i.gradient_limit != '0);
          end else begin
            div_q  <= {dnum, 4'b0000};
            den_q  <= n_q * n_q;
            rem_q  <= '0;
            dcnt_q <= '0;
          end
        end else begin
          if (mul_a_q[0]) acc_q <= acc_q + mul_b_q;
          mul_a_q <= mul_a_q >> 1;
          mul_b_q <= mul_b_q << 1;
        end
      end
      rdvd_pkg::BS_DIV1: begin
        if (div_done) begin
          var_q  <= div_q;
          div_q  <= DW'({step_q, 4'b0000});
          den_q  <= NW'(n_q - 1'b1);
          rem_q  <= '0;
          dcnt_q <= '0;
        end else begin
          div_q  <= {div_q[DW-2:0], ge};
          rem_q  <= r_new[NW-1:0];
          dcnt_q <= dcnt_q + 1'b1;
        end
      end
      rdvd_pkg::BS_DIV2: begin
        if (div_done) begin
          out_q <= {2'b00, div_q[rdvd_pkg::GRAD_W-1:0], var_q[rdvd_pkg::VAR_W-1:0],
                    min_q, dur_q, first_q};
          veh_q <= (var_q[DW-1:4] < PW'(cfg_i.variance_limit)) &&
                   (div_q[DW-1:4] < PW'(cfg_i.gradient_limit));
        end else begin
          div_q  <= {div_q[DW-2:0], ge};
          rem_q  <= r_new[NW-1:0];
          dcnt_q <= dcnt_q + 1'b1;
        end
      end
      default: begin
        veh_q <= veh_q;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdvd_pkg::BS_DIV1 || state_q == rdvd_pkg::BS_DIV2) |-> (den_q != '0))
    else $error("divide by zero in event statistics");
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == rdvd_pkg::BS_MUL2 ||
                            $past(state_q) == rdvd_pkg::BS_DIV2))
    else $error("result shown without finished statistics");
`endif

endmodule

/* sv/range_dip_vehicle_detector_unit.sv */
// ----------------------------------------------------------------------------
// range_dip_vehicle_detector_unit: range dip vehicle detector top level
// Configuration registers, front end, event queue and statistics back end.
// ----------------------------------------------------------------------------
// Each input transfer passes through the front end states READY, where the
// histogram bin of the sample is read, and EXEC, where the bin and the dip
// tracker are updated; EXEC holds while the queue refuses an event, and no
// new sample is taken until it is left. After reset the histogram is swept
// to zero, one bin per cycle, over all HIST_BINS bins (8192 by default),
// before the first input transfer is taken. A reported event costs the back
// end two shift-add products and, from two points, two restoring divisions;
// two events can wait in the queue while the front end keeps taking samples.
// ----------------------------------------------------------------------------
module range_dip_vehicle_detector_unit #(
  parameter int unsigned HIST_BINS     = rdvd_pkg::HIST_BINS_DEF,
  parameter int unsigned EVENT_SAMPLES = rdvd_pkg::EVENT_SAMPLES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [rdvd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rdvd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [rdvd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // time_ms, distance_mm
  input  logic                                  s_axis_tuser,  // op
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // event_start_ms, duration_ms, min_distance_mm, variance_q4, gradient_q4, pad
  output logic [rdvd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tuser   // is_vehicle
);

  localparam int unsigned CW    = $clog2(EVENT_SAMPLES + 1);
  localparam int unsigned SW    = 16 + CW;
  localparam int unsigned QW    = 32 + CW;
  localparam int unsigned REC_W = 64 + CW + 2 * SW + QW;

  rdvd_pkg::cfg_t   cfg_q;
  logic             fq_valid, fq_ready, qb_valid, qb_ready;
  logic [REC_W-1:0] fq_data, qb_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calibration_ms <= rdvd_pkg::CAL_MS_RST;
      cfg_q.merge_gap_ms   <= rdvd_pkg::MERGE_MS_RST;
      cfg_q.min_event_ms   <= rdvd_pkg::MIN_EV_RST;
      cfg_q.max_event_ms   <= rdvd_pkg::MAX_EV_RST;
      cfg_q.dip_margin     <= rdvd_pkg::DIP_MRG_RST;
      cfg_q.min_height     <= rdvd_pkg::MIN_HGT_RST;
      cfg_q.variance_limit <= rdvd_pkg::VAR_LIM_RST;
      cfg_q.gradient_limit <= rdvd_pkg::GRAD_LIM_RST;
    end else if (cfg_we_i) begin
      case (rdvd_pkg::cfg_idx_e'(cfg_idx_i))
        rdvd_pkg::CFG_CAL_MS:   cfg_q.calibration_ms <= cfg_data_i[23:0];
        rdvd_pkg::CFG_MERGE_MS: cfg_q.merge_gap_ms   <= cfg_data_i[15:0];
        rdvd_pkg::CFG_MIN_EV:   cfg_q.min_event_ms   <= cfg_data_i[15:0];
        rdvd_pkg::CFG_MAX_EV:   cfg_q.max_event_ms   <= cfg_data_i[15:0];
        rdvd_pkg::CFG_DIP_MRG:  cfg_q.dip_margin     <= cfg_data_i[11:0];
        rdvd_pkg::CFG_MIN_HGT:  cfg_q.min_height     <= cfg_data_i[11:0];
        rdvd_pkg::CFG_VAR_LIM:  cfg_q.variance_limit <= cfg_data_i;
        rdvd_pkg::CFG_GRAD_LIM: cfg_q.gradient_limit <= cfg_data_i[15:0];
        default:                cfg_q                <= cfg_q;
      endcase
    end
  end

  rdvd_front #(
    .HIST_BINS     (HIST_BINS),
    .EVENT_SAMPLES (EVENT_SAMPLES),
    .REC_W         (REC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_time_i   (s_axis_tdata[31:0]),
    .in_dist_i   (s_axis_tdata[47:32]),
    .rec_valid_o (fq_valid),
    .rec_ready_i (fq_ready),
    .rec_o       (fq_data)
  );

  rdvd_queue #(
    .W     (REC_W),
    .DEPTH (rdvd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_data_o  (qb_data)
  );

  rdvd_back #(
    .EVENT_SAMPLES (EVENT_SAMPLES),
    .REC_W         (REC_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .rec_valid_i   (qb_valid),
    .rec_ready_o   (qb_ready),
    .rec_i         (qb_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_vehicle_o (m_axis_tuser)
  );

endmodule

/* dv/tb_range_dip_vehicle_detector_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_dip_vehicle_detector_unit: self-checking bench of the dip detector
// Drives timestamped range samples and calibration triggers into the input
// stream. A behavioral detector mirrors the histogram, baseline and dip
// tracking and queues each event report it predicts. The output stream is
// checked field by field against that queue. Both streams stall at random.
// ----------------------------------------------------------------------------
module tb_range_dip_vehicle_detector_unit;
  import rdvd_pkg::*;

  typedef struct packed {
    logic [31:0] start_ms;
    logic [15:0] dur_ms;
    logic [15:0] min_mm;
    logic [33:0] var_q4;
    logic [19:0] grad_q4;
    logic        vehicle;
  } event_rec_t;

  localparam int unsigned BINS   = HIST_BINS_DEF;
  localparam int unsigned POINTS = EVENT_SAMPLES_DEF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  range_dip_vehicle_detector_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Detector mirror
  cfg_t            cfg_m;
  phase_e          ph_m;
  logic [31:0]     cal_start_m;
  logic [15:0]     hist_m [0:BINS-1];
  int unsigned     best_bin_m, best_cnt_m, baseline_m;
  logic [31:0]     prev_t_m, last_dip_m, first_t_m, last_t_m;
  logic [15:0]     prev_d_m, last_d_m, ev_min_m;
  bit              prev_ok_m;
  int unsigned     n_pts_m;
  longint unsigned sum_m, sq_sum_m, step_sum_m;

  event_rec_t pending_events [$];
  bit         quiet = 1'b0;
  bit         failed = 1'b0;
  logic [31:0] now_ms = 32'hFFFF_F000;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit below_dip(int unsigned d);
    return longint'(d) < longint'(baseline_m) - longint'(cfg_m.dip_margin);
  endfunction

  function automatic void add_point(logic [31:0] t, logic [15:0] d);
    if (n_pts_m >= POINTS) return;
    if (n_pts_m == 0) begin
      first_t_m = t;
      ev_min_m  = d;
    end else begin
      step_sum_m += (d > last_d_m) ? d - last_d_m : last_d_m - d;
      if (d < ev_min_m) ev_min_m = d;
    end
    sum_m    += d;
    sq_sum_m += longint'(d) * d;
    last_t_m = t;
    last_d_m = d;
    n_pts_m++;
  endfunction

  function automatic void clear_points();
    n_pts_m = 0;
    sum_m = 0;
    sq_sum_m = 0;
    step_sum_m = 0;
  endfunction

  // Close the event; return 1 and fill r when it passes the tests
  function automatic bit close_dip(output event_rec_t r);
    logic [31:0] dur;
    longint unsigned n, nn, num, v_int, v_q4, g_int, g_q4;
    bit ok;
    dur = last_t_m - first_t_m;
    n = n_pts_m;
    v_int = 0; v_q4 = 0; g_int = 0; g_q4 = 0;
    ok = dur >= cfg_m.min_event_ms && dur <= cfg_m.max_event_ms &&
         longint'(ev_min_m) < longint'(baseline_m) - longint'(cfg_m.min_height);
    r = '0;
    if (ok) begin
      if (n >= 2) begin
        nn    = n * n;
        num   = n * sq_sum_m - sum_m * sum_m;
        v_int = num / nn;
        v_q4  = v_int * 16 + ((num % nn) * 16) / nn;
        g_int = step_sum_m / (n - 1);
        g_q4  = (step_sum_m * 16) / (n - 1);
      end
      r.start_ms = first_t_m;
      r.dur_ms   = dur[15:0];
      r.min_mm   = ev_min_m;
      r.var_q4   = v_q4[33:0];
      r.grad_q4  = g_q4[19:0];
      r.vehicle  = v_int < cfg_m.variance_limit && g_int < cfg_m.gradient_limit;
    end
    ph_m = PH_IDLE;
    clear_points();
    return ok;
  endfunction

  function automatic void detector_step(op_e op, logic [31:0] t, logic [15:0] d);
    event_rec_t r;
    int unsigned c;
    if (op == OP_TRIGGER) begin
      if (ph_m == PH_WAIT) begin
        ph_m = PH_CAL;
        cal_start_m = t;
        foreach (hist_m[i]) hist_m[i] = '0;
        best_bin_m = 0;
        best_cnt_m = 0;
      end
      return;
    end
    case (ph_m)
      PH_CAL: begin
        if (t - cal_start_m < {8'd0, cfg_m.calibration_ms}) begin
          if (d < BINS && hist_m[d] != HIST_MAX) begin
            c = hist_m[d] + 1;
            hist_m[d] = c[15:0];
            if (c > best_cnt_m || (c == best_cnt_m && d < best_bin_m)) begin
              best_cnt_m = c;
              best_bin_m = d;
            end
          end
        end else begin
          baseline_m = best_bin_m;
          ph_m = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (below_dip(d)) begin
          ph_m = PH_DIP;
          clear_points();
          if (prev_ok_m) add_point(prev_t_m, prev_d_m);
          add_point(t, d);
          last_dip_m = t;
        end
      end
      PH_DIP: begin
        add_point(t, d);
        if (below_dip(d)) last_dip_m = t;
        else ph_m = PH_MERGE;
      end
      PH_MERGE: begin
        add_point(t, d);
        if (below_dip(d)) begin
          ph_m = PH_DIP;
          last_dip_m = t;
        end else if (t - last_dip_m > {16'd0, cfg_m.merge_gap_ms}) begin
          if (close_dip(r)) pending_events.push_back(r);
        end
      end
      default: ;
    endcase
    prev_t_m = t;
    prev_d_m = d;
    prev_ok_m = 1'b1;
  endfunction

  // Send one item; hold valid high after the transfer for back-to-back items
  task automatic send_item(op_e op, logic [31:0] t, logic [15:0] d);
    while (!quiet && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, t};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    detector_step(op, t, d);
  endtask

  task automatic send_sample(int unsigned step, logic [15:0] d);
    now_ms += step;
    send_item(OP_SAMPLE, now_ms, d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CAL_MS:   cfg_m.calibration_ms = value[23:0];
      CFG_MERGE_MS: cfg_m.merge_gap_ms   = value[15:0];
      CFG_MIN_EV:   cfg_m.min_event_ms   = value[15:0];
      CFG_MAX_EV:   cfg_m.max_event_ms   = value[15:0];
      CFG_DIP_MRG:  cfg_m.dip_margin     = value[11:0];
      CFG_MIN_HGT:  cfg_m.min_height     = value[11:0];
      CFG_VAR_LIM:  cfg_m.variance_limit = value;
      default:      cfg_m.gradient_limit = value[15:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_detection(int unsigned merge, int unsigned mn, int unsigned mx,
                               int unsigned margin, int unsigned height,
                               logic [31:0] var_lim, int unsigned grad_lim);
    drain();
    write_reg(CFG_MERGE_MS, merge);
    write_reg(CFG_MIN_EV, mn);
    write_reg(CFG_MAX_EV, mx);
    write_reg(CFG_DIP_MRG, margin);
    write_reg(CFG_MIN_HGT, height);
    write_reg(CFG_VAR_LIM, var_lim);
    write_reg(CFG_GRAD_LIM, grad_lim);
  endtask

  // Samples before the trigger only set the previous-sample context
  task automatic test_pre_trigger();
    send_item(OP_SAMPLE, 32'h0000_0000, 16'h0000);
    send_item(OP_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_SAMPLE, 32'h5555_AAAA, 16'd100);
  endtask

  // Build the histogram: ignored second trigger, out-of-range bins, ties,
  // a dominant bin, then close the window with an aged sample
  task automatic test_calibration();
    send_item(OP_TRIGGER, now_ms, 16'd0);
    send_item(OP_TRIGGER, now_ms + 100, 16'd7);
    send_sample(1, 16'd8191);
    send_sample(1, 16'd8192);
    send_sample(1, 16'hFFFF);
    send_sample(1, 16'd600);
    send_sample(1, 16'd600);
    send_sample(1, 16'd520);
    send_sample(1, 16'd520);
    quiet = 1'b1;
    repeat (20) send_item(OP_SAMPLE, now_ms, 16'd500);
    quiet = 1'b0;
    send_sample(3000, 16'd505);
  endtask

  task automatic dip_event(int unsigned len, int unsigned step, int unsigned depth);
    int unsigned th;
    th = baseline_m - cfg_m.dip_margin;
    send_sample(step, th[15:0]);
    repeat (len) send_sample(step, 16'(th - 1 - $urandom_range(depth)));
    send_sample(step, 16'(baseline_m + 2));
    send_sample(cfg_m.merge_gap_ms + 1, 16'(baseline_m + 1));
  endtask

  // Accepted, too short, too shallow, merged and long back-to-back events
  task automatic test_directed_events();
    dip_event(20, 50, 200);
    dip_event(3, 10, 200);
    dip_event(20, 50, 5);
    send_sample(40, 16'd300);
    send_sample(150, 16'd510);
    send_sample(40, 16'd0);
    send_sample(40, 16'd510);
    send_sample(250, 16'd510);
    quiet = 1'b1;
    dip_event(60, 10, 100);
    quiet = 1'b0;
  endtask

  task automatic test_random_events(int unsigned items);
    int unsigned sent, th, len, k;
    sent = 0;
    while (sent < items) begin
      k = $urandom_range(99);
      if (k < 8) begin
        if (k < 2) send_item(OP_TRIGGER, $urandom, 16'($urandom));
        else send_item(OP_SAMPLE, now_ms + $urandom, 16'($urandom));
        now_ms = prev_t_m;
        sent++;
      end else begin
        repeat ($urandom_range(3)) send_sample($urandom_range(1, 150),
                                               16'(baseline_m + $urandom_range(20)));
        th = (baseline_m > cfg_m.dip_margin) ? baseline_m - cfg_m.dip_margin : 0;
        len = $urandom_range(1, 25);
        repeat (len) begin
          if (th > 0 && $urandom_range(9) != 0)
            send_sample($urandom_range(1, 150), 16'(th - 1 - $urandom_range(th - 1 < 300 ?
                                                                             th - 1 : 300)));
          else
            send_sample($urandom_range(1, 300), 16'(th + $urandom_range(30)));
        end
        send_sample($urandom_range(1, 300), 16'(th + $urandom_range(30)));
        send_sample(cfg_m.merge_gap_ms + $urandom_range(1, 50), 16'(baseline_m + 3));
        sent += len + 2;
      end
    end
  endtask

  // Check each result transfer against the oldest predicted event
  always @(posedge clk_i) begin
    event_rec_t want, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[63:48],
             m_axis_tdata[97:64], m_axis_tdata[117:98], m_axis_tuser};
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_events.pop_front();
        if (got.start_ms != want.start_ms || got.dur_ms != want.dur_ms ||
            got.min_mm != want.min_mm || got.var_q4 != want.var_q4 ||
            got.grad_q4 != want.grad_q4 || got.vehicle != want.vehicle) begin
          $display("%0t: event mismatch expected %h actual %h", $time, want, got);
          failed = 1'b1;
        end
      end
    end
  end

  // Stall the result stream at random
  always @(posedge clk_i) m_axis_tready <= quiet || $urandom_range(99) >= 36;

  initial begin
    cfg_m = {CAL_MS_RST, MERGE_MS_RST, MIN_EV_RST, MAX_EV_RST, DIP_MRG_RST,
             MIN_HGT_RST, VAR_LIM_RST, GRAD_LIM_RST};
    ph_m = PH_WAIT;
    cal_start_m = '0;
    foreach (hist_m[i]) hist_m[i] = '0;
    best_bin_m = 0; best_cnt_m = 0; baseline_m = BASELINE_RST;
    prev_t_m = '0; prev_d_m = '0; prev_ok_m = 1'b0;
    last_dip_m = '0; first_t_m = '0; last_t_m = '0; last_d_m = '0; ev_min_m = '0;
    clear_points();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(CFG_CAL_MS, 32'd3000);

    test_pre_trigger();
    test_calibration();
    test_directed_events();
    test_random_events(150);
    set_detection(0, 0, 65535, 0, 0, 32'hFFFF_FFFF, 65535);
    write_reg(CFG_CAL_MS, 32'h00FF_FFFF);
    test_random_events(250);
    set_detection(65535, 100, 2000, 40, 4095, 32'd0, 0);
    write_reg(CFG_CAL_MS, 32'd0);
    test_random_events(150);
    set_detection(300, 0, 0, 4095, 0, 32'd2000, 20);
    test_random_events(100);
    set_detection(200, 200, 5000, 20, 60, 32'd4800, 35);
    quiet = 1'b1;
    test_random_events(150);
    quiet = 1'b0;
    test_random_events(150);

    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* range_dip_vehicle_detector_unit.f */
sv/rdvd_pkg.sv
sv/rdvd_queue.sv
sv/rdvd_front.sv
sv/rdvd_back.sv
sv/range_dip_vehicle_detector_unit.sv
dv/tb_range_dip_vehicle_detector_unit.sv
